[sv/bitmap_slot_allocator_core_macros.svh]
// Assertion macros used by the checker file of the slot allocator.
// No dependencies; take by `include with the bare file name.
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define BSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator check failed");

`endif

[sv/bsa_pkg.sv]
// Shared types, constants and codes of the bitmap slot allocator.
// No dependencies; the design and checker files refer to it by scoped names.
package bsa_pkg;

   localparam int MAX_SLOTS   = 4096;
   localparam int WORD_BITS   = 32;
   localparam int WORD_COUNT  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW     = $clog2(WORD_COUNT);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int SLOT_W      = 12;
   localparam int COUNT_W     = 13;
   localparam int COUNTER_CAP = (MAX_SLOTS < 8191) ? MAX_SLOTS : 8191;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   // register indexes
   localparam logic [1:0] REG_SLOT_COUNT   = 2'd0;
   localparam logic [1:0] REG_RESERVE_ZERO = 2'd1;
   localparam logic [1:0] REG_FREE_START   = 2'd2;

   // actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NONE_FREE = 2'd1;
   localparam logic [1:0] STAT_RANGE     = 2'd2;

   typedef struct packed {
      logic              action;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [SLOT_W-1:0]  granted_index;
      logic [COUNT_W-1:0] free_left;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] slot_count;
      logic               reserve_zero;
      logic               load;
      logic [COUNT_W-1:0] load_value;
   } cfg_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WORD_AW-1:0]   rd_addr;
      logic                 wr_en;
      logic [WORD_AW-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } mem_req_type;

endpackage

[sv/bsa_csr.sv]
// Configuration registers of the slot allocator behind the APB-style port.
// Depends on bsa_pkg.
module bsa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bsa_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bsa_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bsa_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output bsa_pkg::cfg_type             cfg
);

   logic [bsa_pkg::COUNT_W-1:0] slot_count_ff, slot_count_in;
   logic                        reserve_ff, reserve_in;
   logic [bsa_pkg::COUNT_W-1:0] start_ff, start_in;
   logic                        wr_hit;
   logic [1:0]                  reg_idx;
   logic [bsa_pkg::COUNT_W-1:0] wr_val;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_val     = csr_pwdata[bsa_pkg::COUNT_W-1:0];

   always_comb begin
      slot_count_in = slot_count_ff;
      reserve_in    = reserve_ff;
      start_in      = start_ff;
      if (wr_hit) begin
         case (reg_idx)
            bsa_pkg::REG_SLOT_COUNT:   slot_count_in = wr_val;
            bsa_pkg::REG_RESERVE_ZERO: reserve_in    = csr_pwdata[0];
            bsa_pkg::REG_FREE_START:   start_in      = wr_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= bsa_pkg::COUNT_W'(bsa_pkg::MAX_SLOTS);
         reserve_ff    <= 1'b0;
         start_ff      <= bsa_pkg::COUNT_W'(4096);
      end else begin
         slot_count_ff <= slot_count_in;
         reserve_ff    <= reserve_in;
         start_ff      <= start_in;
      end
   end

   always_comb begin
      case (reg_idx)
         bsa_pkg::REG_SLOT_COUNT:
            csr_prdata = bsa_pkg::CSR_DW'(slot_count_ff);
         bsa_pkg::REG_RESERVE_ZERO:
            csr_prdata = bsa_pkg::CSR_DW'(reserve_ff);
         bsa_pkg::REG_FREE_START:
            csr_prdata = bsa_pkg::CSR_DW'(start_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // clamp the counter load to the counter cap
   always_comb begin
      cfg.slot_count   = slot_count_ff;
      cfg.reserve_zero = reserve_ff;
      cfg.load         = wr_hit && (reg_idx == bsa_pkg::REG_FREE_START);
      cfg.load_value   = (wr_val > bsa_pkg::COUNT_W'(bsa_pkg::COUNTER_CAP)) ?
                         bsa_pkg::COUNT_W'(bsa_pkg::COUNTER_CAP) : wr_val;
   end

endmodule

[sv/bsa_bitmap_mem.sv]
// Used/free bitmap store: one word per address, registered read, one write port.
// Per-word valid flops make unwritten words read as all free. Depends on bsa_pkg.
module bsa_bitmap_mem (
   input  logic                            clock,
   input  logic                            reset,
   input  bsa_pkg::mem_req_type            mem_req,
   output logic [bsa_pkg::WORD_BITS-1:0]   rd_data
);

   logic [bsa_pkg::WORD_BITS-1:0]  mem_ff [bsa_pkg::WORD_COUNT];
   logic [bsa_pkg::WORD_COUNT-1:0] valid_ff;
   logic [bsa_pkg::WORD_BITS-1:0]  rd_data_ff;
   logic                           rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff  <= mem_ff[mem_req.rd_addr];
         rd_valid_ff <= valid_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   // a word never written holds all slots free
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[sv/bitmap_slot_allocator_core.sv]
// Allocate: the request is taken in idle, then the scan state checks one word per cycle
// until a clear bit is found or the last word is done; free reads the slot's word and
// writes it back in the free state; a rejected request goes straight to the out state.
// One request at a time: the request side stalls from acceptance until the result is
// loaded into the result register. Reset: synchronous; bitmap valid flops clear,
// counter returns to its cap, no clearing pass.
module bitmap_slot_allocator_core (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bsa_pkg::req_type             req_payload,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bsa_pkg::rsp_type             rsp_payload,
   // configuration port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bsa_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bsa_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bsa_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FREE = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   localparam int WA = bsa_pkg::WORD_AW;
   localparam int BW = bsa_pkg::BIT_W;
   localparam int WB = bsa_pkg::WORD_BITS;
   localparam int CW = bsa_pkg::COUNT_W;
   localparam int SW = bsa_pkg::SLOT_W;

   bsa_pkg::cfg_type     cfg;
   bsa_pkg::mem_req_type mem_req;
   logic [WB-1:0]        rd_data;

   logic [1:0]           state_ff, state_in;
   logic [WA-1:0]        word_ff, word_in;
   logic [SW-1:0]        index_ff, index_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   bsa_pkg::rsp_type     res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bsa_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 accept;
   logic                 out_free;
   logic [CW-1:0]        limit;
   logic [CW-1:0]        limit_m1;
   logic [WA-1:0]        last_word;
   logic [WB-1:0]        hi_mask;
   logic [WB-1:0]        lo_mask;
   logic [WB-1:0]        cand;
   logic                 found;
   logic [BW-1:0]        pos;
   logic [CW-1:0]        cnt_inc;

   bsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bsa_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // one request in flight; the result register decouples the response side
   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // live slot count, clamped to the bitmap size
   assign limit     = (cfg.slot_count > CW'(bsa_pkg::MAX_SLOTS)) ?
                      CW'(bsa_pkg::MAX_SLOTS) : cfg.slot_count;
   assign limit_m1  = limit - CW'(1);
   assign last_word = limit_m1[SW-1:BW];

   // searchable bits of the word now on the read port
   assign hi_mask = ({1'b0, word_ff} == limit[CW-1:BW]) ?
                    ~({WB{1'b1}} << limit[BW-1:0]) : {WB{1'b1}};
   assign lo_mask = (cfg.reserve_zero && (word_ff == '0)) ?
                    ~(WB'(1)) : {WB{1'b1}};
   assign cand    = ~rd_data & hi_mask & lo_mask;
   assign found   = |cand;

   // lowest clear bit
   always_comb begin
      pos = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pos = BW'(i);
         end
      end
   end

   assign cnt_inc = (cnt_ff < CW'(bsa_pkg::COUNTER_CAP)) ? cnt_ff + CW'(1) : cnt_ff;

   always_comb begin
      state_in        = state_ff;
      word_in         = word_ff;
      index_in        = index_ff;
      cnt_in          = cnt_ff;
      res_in          = res_ff;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = word_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = word_ff;
      mem_req.wr_data = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               index_in             = req_payload.slot_index;
               res_in.granted_index = '0;
               res_in.free_left     = cnt_ff;
               if (req_payload.action == bsa_pkg::ACT_FREE) begin
                  if ({1'b0, req_payload.slot_index} >= limit) begin
                     res_in.status = bsa_pkg::STAT_RANGE;
                     state_in      = S_OUT;
                  end else begin
                     // fetch the word that holds the slot
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = req_payload.slot_index[SW-1:BW];
                     state_in        = S_FREE;
                  end
               end else if ((cnt_ff == '0) || (limit == '0)) begin
                  res_in.status = bsa_pkg::STAT_NONE_FREE;
                  state_in      = S_OUT;
               end else begin
                  // start the scan at word zero
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
                  word_in         = '0;
                  state_in        = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               // claim the slot and write the word back
               mem_req.wr_en        = 1'b1;
               mem_req.wr_addr      = word_ff;
               mem_req.wr_data      = rd_data | (WB'(1) << pos);
               cnt_in               = cnt_ff - CW'(1);
               res_in.status        = bsa_pkg::STAT_OK;
               res_in.granted_index = {word_ff, pos};
               res_in.free_left     = cnt_ff - CW'(1);
               state_in             = S_OUT;
            end else if (word_ff == last_word) begin
               res_in.status = bsa_pkg::STAT_NONE_FREE;
               state_in      = S_OUT;
            end else begin
               // advance to the next word
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = word_ff + WA'(1);
               word_in         = word_ff + WA'(1);
            end
         end
         S_FREE: begin
            mem_req.wr_en    = 1'b1;
            mem_req.wr_addr  = index_ff[SW-1:BW];
            mem_req.wr_data  = rd_data & ~(WB'(1) << index_ff[BW-1:0]);
            cnt_in           = cnt_inc;
            res_in.status    = bsa_pkg::STAT_OK;
            res_in.free_left = cnt_inc;
            state_in         = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // counter load from the start register; the user must write it only while idle, not enforced here
      if (cfg.load) begin
         cnt_in = cfg.load_value;
      end
   end

   // result register: load from the pending result, drop once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= CW'(bsa_pkg::COUNTER_CAP);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      index_ff <= index_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[sv/bsa_checker.sv]
// Port-level checks of the slot allocator, bound to the top level.
// Depends on bsa_pkg and bitmap_slot_allocator_core_macros.svh.
`include "bitmap_slot_allocator_core_macros.svh"

module bsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bsa_pkg::rsp_type rsp_payload
);

   // a transfer in starts work, so the request side closes next cycle
   `BSA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // a stalled result holds
   `BSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // no undefined status code
   `BSA_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, rsp_payload.status != 2'd3)

   // only a granted slot carries an index
   `BSA_ASSERT_SAME(a_grant_zero, clock, reset, rsp_valid && (rsp_payload.status != bsa_pkg::STAT_OK), rsp_payload.granted_index == '0)

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
